### rtl/core/mse_pkg.sv
// Shared constants and item types for the merge sort engine.
package mse_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int DATA_W        = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } mse_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } mse_res_t;

endpackage

### rtl/core/mse_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
module mse_ram import mse_pkg::*; #(
  parameter int DEPTH  = MAX_ITEMS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ADDR_W-1:0]        waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [ADDR_W-1:0]        raddr_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/merge_sort_engine.sv
// Merge sort engine: collects a set of signed values and emits them sorted.
//
// Input: an item {value, last} transfers at a clock edge with start_i high and
// busy_o low. Values are written into a store of MAX_ITEMS entries, one per
// cycle; values beyond the capacity are dropped and the set is marked overflow.
// The item with last set closes the set (busy_o rises) and starts the sort, or
// the output directly for a single item. Sorting is a stable bottom-up merge
// that ping-pongs between two RAMs with registered read ports. Each pass walks
// the runs with one read and one write per cycle: a pair of runs goes through
// SETUP_A and SETUP_B, then MERGE; there are ceil(log2 n) passes.
// Output then reads the final RAM, one result per cycle, n results in total,
// each shown for one cycle with res_valid_o; the last carries final_res.
// busy_o falls in the cycle the final result shows, so the next set may
// start loading while that result is on the ports. Merge reads and writes hit
// different RAMs, so no forwarding is needed.
// Results cannot be held off by the receiver. Reset clears the count, the
// overflow mark, the state and the result flags; pointers and RAMs need no clearing.
module merge_sort_engine import mse_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  mse_in_t  in_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output mse_res_t res_o
);

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SETUP_A = 3'd1;
  localparam logic [2:0] ST_SETUP_B = 3'd2;
  localparam logic [2:0] ST_MERGE   = 3'd3;
  localparam logic [2:0] ST_OUT     = 3'd4;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_A    = 2'd1;
  localparam logic [1:0] PEND_B    = 2'd2;

  logic [2:0]               state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     drop_q, drop_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic [SUM_W-1:0]         w_q, w_d;
  logic [CNT_W-1:0]         lo_q, lo_d;
  logic [CNT_W-1:0]         i_q, i_d;
  logic [CNT_W-1:0]         j_q, j_d;
  logic [CNT_W-1:0]         k_q, k_d;
  logic [CNT_W-1:0]         mid_q, mid_d;
  logic [CNT_W-1:0]         hi_q, hi_d;
  logic signed [DATA_W-1:0] a_q, a_d;
  logic signed [DATA_W-1:0] b_q, b_d;
  logic [1:0]               pend_q, pend_d;
  logic                     sel_q, sel_d;
  logic                     res_vld_q, res_vld_d;
  logic                     res_fin_q, res_fin_d;
  logic                     res_ovf_q, res_ovf_d;

  logic                     ld_we, mg_we, rd_en;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] rdata0, rdata1, rdata;
  logic signed [DATA_W-1:0] a_eff, b_eff;
  logic                     left_ok, right_ok, take_left;
  logic [SUM_W-1:0]         lo_w, n_w, mid_s, hi_s, w2;
  logic [CNT_W-1:0]         cnt_nx, i_nx, j_nx, k_nx;

  assign rdata = sel_q ? rdata1 : rdata0;

  // Merge heads: a head reloaded last cycle comes straight from the RAM.
  assign a_eff     = (pend_q == PEND_A) ? rdata : a_q;
  assign b_eff     = (pend_q == PEND_B) ? rdata : b_q;
  assign left_ok   = i_q < mid_q;
  assign right_ok  = j_q < hi_q;
  assign take_left = left_ok && (!right_ok || (a_eff <= b_eff));

  assign lo_w  = SUM_W'(lo_q);
  assign n_w   = SUM_W'(n_q);
  assign w2    = w_q << 1;
  assign mid_s = lo_w + w_q;
  assign hi_s  = lo_w + w2;
  assign i_nx  = i_q + CNT_W'(1);
  assign j_nx  = j_q + CNT_W'(1);
  assign k_nx  = k_q + CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    drop_d    = drop_q;
    n_d       = n_q;
    w_d       = w_q;
    lo_d      = lo_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    a_d       = a_q;
    b_d       = b_q;
    pend_d    = pend_q;
    sel_d     = sel_q;
    res_vld_d = 1'b0;
    res_fin_d = 1'b0;
    res_ovf_d = res_ovf_q;
    ld_we     = 1'b0;
    mg_we     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_addr   = k_q[ADDR_W-1:0];
    wr_data   = take_left ? a_eff : b_eff;
    cnt_nx    = count_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (count_q < MAX_CNT) begin
            ld_we   = 1'b1;
            wr_addr = count_q[ADDR_W-1:0];
            wr_data = in_i.value;
            cnt_nx  = count_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          count_d = cnt_nx;
          if (in_i.last) begin
            n_d   = cnt_nx;
            sel_d = 1'b0;
            lo_d  = '0;
            k_d   = '0;
            if (cnt_nx > CNT_W'(1)) begin
              w_d     = SUM_W'(1);
              state_d = ST_SETUP_A;
            end else begin
              state_d = ST_OUT;
            end
          end
        end
      end

      ST_SETUP_A: begin
        mid_d   = (mid_s < n_w) ? mid_s[CNT_W-1:0] : n_q;
        hi_d    = (hi_s < n_w) ? hi_s[CNT_W-1:0] : n_q;
        i_d     = lo_q;
        j_d     = mid_d;
        k_d     = lo_q;
        rd_en   = 1'b1;
        rd_addr = lo_q[ADDR_W-1:0];
        state_d = ST_SETUP_B;
      end

      ST_SETUP_B: begin
        a_d = rdata;
        if (j_q < hi_q) begin
          rd_en   = 1'b1;
          rd_addr = j_q[ADDR_W-1:0];
          pend_d  = PEND_B;
        end else begin
          pend_d  = PEND_NONE;
        end
        state_d = ST_MERGE;
      end

      ST_MERGE: begin
        a_d    = a_eff;
        b_d    = b_eff;
        mg_we  = 1'b1;
        k_d    = k_nx;
        pend_d = PEND_NONE;
        // Refill the head that was just consumed.
        if (take_left) begin
          i_d = i_nx;
          if (i_nx < mid_q) begin
            rd_en   = 1'b1;
            rd_addr = i_nx[ADDR_W-1:0];
            pend_d  = PEND_A;
          end
        end else begin
          j_d = j_nx;
          if (j_nx < hi_q) begin
            rd_en   = 1'b1;
            rd_addr = j_nx[ADDR_W-1:0];
            pend_d  = PEND_B;
          end
        end
        if (k_nx == hi_q) begin
          if (hi_s < n_w) begin
            lo_d    = hi_s[CNT_W-1:0];
            state_d = ST_SETUP_A;
          end else begin
            // Pass done: swap source and destination RAMs.
            sel_d = ~sel_q;
            w_d   = w2;
            lo_d  = '0;
            if (w2 < n_w) begin
              state_d = ST_SETUP_A;
            end else begin
              k_d     = '0;
              state_d = ST_OUT;
            end
          end
        end
      end

      ST_OUT: begin
        rd_en     = 1'b1;
        rd_addr   = k_q[ADDR_W-1:0];
        res_vld_d = 1'b1;
        res_fin_d = (k_nx == n_q);
        res_ovf_d = drop_q;
        k_d       = k_nx;
        if (k_nx == n_q) begin
          count_d = '0;
          drop_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      drop_q    <= 1'b0;
      pend_q    <= PEND_NONE;
      sel_q     <= 1'b0;
      res_vld_q <= 1'b0;
      res_fin_q <= 1'b0;
      res_ovf_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      drop_q    <= drop_d;
      pend_q    <= pend_d;
      sel_q     <= sel_d;
      res_vld_q <= res_vld_d;
      res_fin_q <= res_fin_d;
      res_ovf_q <= res_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    w_q   <= w_d;
    lo_q  <= lo_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  mse_ram #(
    .DEPTH  (MAX_ITEMS),
    .ADDR_W (ADDR_W)
  ) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (ld_we | (mg_we & sel_q)),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  mse_ram #(
    .DEPTH  (MAX_ITEMS),
    .ADDR_W (ADDR_W)
  ) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (mg_we & ~sel_q),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  assign busy_o             = (state_q != ST_IDLE);
  assign res_valid_o        = res_vld_q;
  assign res_o.sorted_value = rdata;
  assign res_o.final_res    = res_fin_q;
  assign res_o.overflow     = res_ovf_q;

endmodule

### rtl/core/mse_checker.sv
// Port-level checker for the merge sort engine, bound to the top level.
module mse_checker import mse_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input mse_in_t  in_i,
  input logic     busy_i,
  input logic     res_valid_i,
  input mse_res_t res_i
);

  // A closing transfer always starts a sort or an output run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && in_i.last) |=> busy_i)
    else $error("closing transfer did not raise busy");

  // Results only follow a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> $past(busy_i))
    else $error("result without preceding busy cycle");

  // Nothing follows the final result directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_i.final_res) |=> !res_valid_i)
    else $error("result right after final result");

  // Busy drops only as the final result is issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> (res_valid_i && res_i.final_res))
    else $error("busy fell without a final result");

  // Overflow mark is the same on all results of one set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && $past(res_valid_i) && !$past(res_i.final_res))
      |-> (res_i.overflow == $past(res_i.overflow)))
    else $error("overflow changed within a set");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .in_i        (in_i),
  .busy_i      (busy_o),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
